// ----- sv/ibpd_pkg.sv -----
// Shared constants, codes and types of the block pooling downsampler.
package ibpd_pkg;

   localparam int MAX_SOURCE_HEIGHT = 4096;
   localparam int MAX_FACTOR        = 16;
   localparam int PIXEL_BITS        = 24;

   localparam int ROW_BITS       = $clog2(MAX_SOURCE_HEIGHT);
   localparam int IN_BLOCK_BITS  = $clog2(MAX_FACTOR);
   localparam int SIZE_REG_BITS  = 13;
   localparam int FACTOR_REG_BITS = 5;
   localparam int MODE_BITS      = 2;
   localparam int OUT_INDEX_BITS = 12;
   localparam int ACC_BITS       = 32;
   localparam int DIV_BITS       = 2 * FACTOR_REG_BITS;
   localparam int DIV_STEP_BITS  = $clog2(ACC_BITS);
   localparam int CHECK_STEP_BITS = $clog2(SIZE_REG_BITS);

   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;

   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

   localparam int RSP_DATA_BITS = 56;
   localparam int REQ_DATA_BITS = 24;

   localparam logic [MODE_BITS-1:0] MODE_SUM = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_AVG = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_MAX = 2'd2;

   localparam logic [2:0] REG_SOURCE_HEIGHT = 3'd0;
   localparam logic [2:0] REG_SOURCE_WIDTH  = 3'd1;
   localparam logic [2:0] REG_HEIGHT_FACTOR = 3'd2;
   localparam logic [2:0] REG_WIDTH_FACTOR  = 3'd3;
   localparam logic [2:0] REG_POOL_MODE     = 3'd4;

   typedef struct packed {
      logic [SIZE_REG_BITS-1:0]   source_height;
      logic [SIZE_REG_BITS-1:0]   source_width;
      logic [FACTOR_REG_BITS-1:0] height_factor;
      logic [FACTOR_REG_BITS-1:0] width_factor;
      logic [MODE_BITS-1:0]       pool_mode;
      logic                       ok;
      logic                       busy;
      logic                       restart;
   } cfg_type;

   typedef struct packed {
      logic [PIXEL_BITS-1:0]     pixel;
      logic [OUT_INDEX_BITS-1:0] column;
      logic [OUT_INDEX_BITS-1:0] row;
      logic                      first;
      logic                      emit;
      logic                      last;
      logic                      bad;
   } item_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_UPDATE,
      BK_DIVIDE,
      BK_OUTPUT
   } back_state_type;

endpackage

// ----- sv/ibpd_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module ibpd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ----- sv/ibpd_regs.sv -----
// Configuration registers, register read-back and the divisibility check.
module ibpd_regs (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [ibpd_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [ibpd_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [ibpd_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                 csr_pready,
   output ibpd_pkg::cfg_type                    cfg
);

   logic [ibpd_pkg::SIZE_REG_BITS-1:0]   height_ff, width_ff;
   logic [ibpd_pkg::FACTOR_REG_BITS-1:0] hfac_ff, wfac_ff;
   logic [ibpd_pkg::MODE_BITS-1:0]       mode_ff;
   logic                                 ok_ff, ok_in;
   logic                                 busy_ff, busy_in;
   logic [ibpd_pkg::CHECK_STEP_BITS-1:0] step_ff, step_in;
   logic [ibpd_pkg::FACTOR_REG_BITS-1:0] rem_h_ff, rem_h_in, rem_w_ff, rem_w_in;
   logic [ibpd_pkg::FACTOR_REG_BITS:0]   shift_h, shift_w;
   logic [2:0]                           index;
   logic                                 wr, hit;
   logic                                 range_ok;

   assign csr_pready = 1'b1;
   assign index = csr_paddr[4:2];
   assign wr    = csr_psel && csr_penable && csr_pwrite;
   assign hit   = wr && (index == ibpd_pkg::REG_SOURCE_HEIGHT ||
                         index == ibpd_pkg::REG_SOURCE_WIDTH  ||
                         index == ibpd_pkg::REG_HEIGHT_FACTOR ||
                         index == ibpd_pkg::REG_WIDTH_FACTOR  ||
                         index == ibpd_pkg::REG_POOL_MODE);

   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff <= ibpd_pkg::SIZE_REG_BITS'(1);
         width_ff  <= ibpd_pkg::SIZE_REG_BITS'(1);
         hfac_ff   <= ibpd_pkg::FACTOR_REG_BITS'(1);
         wfac_ff   <= ibpd_pkg::FACTOR_REG_BITS'(1);
         mode_ff   <= ibpd_pkg::MODE_SUM;
      end else if (wr) begin
         case (index)
            ibpd_pkg::REG_SOURCE_HEIGHT: height_ff <= csr_pwdata[ibpd_pkg::SIZE_REG_BITS-1:0];
            ibpd_pkg::REG_SOURCE_WIDTH:  width_ff  <= csr_pwdata[ibpd_pkg::SIZE_REG_BITS-1:0];
            ibpd_pkg::REG_HEIGHT_FACTOR: hfac_ff   <= csr_pwdata[ibpd_pkg::FACTOR_REG_BITS-1:0];
            ibpd_pkg::REG_WIDTH_FACTOR:  wfac_ff   <= csr_pwdata[ibpd_pkg::FACTOR_REG_BITS-1:0];
            ibpd_pkg::REG_POOL_MODE:     mode_ff   <= csr_pwdata[ibpd_pkg::MODE_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         ibpd_pkg::REG_SOURCE_HEIGHT: csr_prdata = ibpd_pkg::CSR_DATA_BITS'(height_ff);
         ibpd_pkg::REG_SOURCE_WIDTH:  csr_prdata = ibpd_pkg::CSR_DATA_BITS'(width_ff);
         ibpd_pkg::REG_HEIGHT_FACTOR: csr_prdata = ibpd_pkg::CSR_DATA_BITS'(hfac_ff);
         ibpd_pkg::REG_WIDTH_FACTOR:  csr_prdata = ibpd_pkg::CSR_DATA_BITS'(wfac_ff);
         ibpd_pkg::REG_POOL_MODE:     csr_prdata = ibpd_pkg::CSR_DATA_BITS'(mode_ff);
         default:                     csr_prdata = '0;
      endcase
   end

   // Both sizes are reduced modulo their factors one bit per cycle, MSB first.
   assign range_ok =
      height_ff != '0 && height_ff <= ibpd_pkg::SIZE_REG_BITS'(ibpd_pkg::MAX_SOURCE_HEIGHT) &&
      width_ff  != '0 && width_ff  <= ibpd_pkg::SIZE_REG_BITS'(ibpd_pkg::MAX_SOURCE_HEIGHT) &&
      hfac_ff   != '0 && hfac_ff   <= ibpd_pkg::FACTOR_REG_BITS'(ibpd_pkg::MAX_FACTOR) &&
      wfac_ff   != '0 && wfac_ff   <= ibpd_pkg::FACTOR_REG_BITS'(ibpd_pkg::MAX_FACTOR);

   always_comb begin
      shift_h  = {rem_h_ff, height_ff[step_ff]};
      shift_w  = {rem_w_ff, width_ff[step_ff]};
      rem_h_in = shift_h[ibpd_pkg::FACTOR_REG_BITS-1:0];
      rem_w_in = shift_w[ibpd_pkg::FACTOR_REG_BITS-1:0];
      if (shift_h >= {1'b0, hfac_ff}) begin
         rem_h_in = ibpd_pkg::FACTOR_REG_BITS'(shift_h - {1'b0, hfac_ff});
      end
      if (shift_w >= {1'b0, wfac_ff}) begin
         rem_w_in = ibpd_pkg::FACTOR_REG_BITS'(shift_w - {1'b0, wfac_ff});
      end
      ok_in   = ok_ff;
      busy_in = busy_ff;
      step_in = step_ff;
      if (busy_ff) begin
         step_in = step_ff - 1'b1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
            ok_in   = range_ok && rem_h_in == '0 && rem_w_in == '0;
         end
      end
      if (hit) begin
         busy_in  = 1'b1;
         step_in  = ibpd_pkg::CHECK_STEP_BITS'(ibpd_pkg::SIZE_REG_BITS - 1);
         rem_h_in = '0;
         rem_w_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ok_ff    <= 1'b1;
         busy_ff  <= 1'b0;
         step_ff  <= '0;
         rem_h_ff <= '0;
         rem_w_ff <= '0;
      end else begin
         ok_ff    <= ok_in;
         busy_ff  <= busy_in;
         step_ff  <= step_in;
         rem_h_ff <= rem_h_in;
         rem_w_ff <= rem_w_in;
      end
   end

   always_comb begin
      cfg.source_height = height_ff;
      cfg.source_width  = width_ff;
      cfg.height_factor = hfac_ff;
      cfg.width_factor  = wfac_ff;
      cfg.pool_mode     = mode_ff;
      cfg.ok            = ok_ff;
      cfg.busy          = busy_ff;
      cfg.restart       = hit;
   end

endmodule

// ----- sv/ibpd_front.sv -----
// Front end: accepts pixels, tracks the scan position and classifies each item.
module ibpd_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ibpd_pkg::cfg_type                    cfg,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [ibpd_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   input  logic                                 q_full,
   output logic                                 q_push,
   output ibpd_pkg::item_type                   q_item
);

   logic [ibpd_pkg::ROW_BITS-1:0]       src_row_ff, src_row_in, src_col_ff, src_col_in;
   logic [ibpd_pkg::IN_BLOCK_BITS-1:0]  rib_ff, rib_in, cib_ff, cib_in;
   logic [ibpd_pkg::OUT_INDEX_BITS-1:0] orc_ff, orc_in, occ_ff, occ_in;
   logic [ibpd_pkg::SIZE_REG_BITS-1:0]  row_next, col_next;
   logic [ibpd_pkg::FACTOR_REG_BITS-1:0] rib_next, cib_next;

   assign req_tready = !cfg.busy && !q_full;
   assign q_push     = req_tvalid && req_tready;

   always_comb begin
      q_item.pixel  = req_tdata[ibpd_pkg::PIXEL_BITS-1:0];
      q_item.column = occ_ff;
      q_item.row    = orc_ff;
      q_item.first  = rib_ff == '0 && cib_ff == '0;
      q_item.emit   = ibpd_pkg::FACTOR_REG_BITS'(rib_ff) == cfg.height_factor - 1'b1 &&
                      ibpd_pkg::FACTOR_REG_BITS'(cib_ff) == cfg.width_factor - 1'b1;
      q_item.last   = ibpd_pkg::SIZE_REG_BITS'(src_row_ff) == cfg.source_height - 1'b1 &&
                      ibpd_pkg::SIZE_REG_BITS'(src_col_ff) == cfg.source_width - 1'b1;
      q_item.bad    = !cfg.ok;
      if (!cfg.ok) begin
         q_item.pixel  = '0;
         q_item.column = '0;
         q_item.row    = '0;
         q_item.first  = 1'b0;
         q_item.emit   = 1'b0;
         q_item.last   = 1'b0;
      end
   end

   always_comb begin
      row_next   = ibpd_pkg::SIZE_REG_BITS'(src_row_ff) + 1'b1;
      col_next   = ibpd_pkg::SIZE_REG_BITS'(src_col_ff) + 1'b1;
      rib_next   = ibpd_pkg::FACTOR_REG_BITS'(rib_ff) + 1'b1;
      cib_next   = ibpd_pkg::FACTOR_REG_BITS'(cib_ff) + 1'b1;
      src_row_in = src_row_ff;
      src_col_in = src_col_ff;
      rib_in     = rib_ff;
      cib_in     = cib_ff;
      orc_in     = orc_ff;
      occ_in     = occ_ff;
      if (q_push && cfg.ok) begin
         src_row_in = row_next[ibpd_pkg::ROW_BITS-1:0];
         rib_in     = rib_next[ibpd_pkg::IN_BLOCK_BITS-1:0];
         if (rib_next >= cfg.height_factor) begin
            rib_in = '0;
            orc_in = orc_ff + 1'b1;
         end
         if (row_next >= cfg.source_height) begin
            // End of a source column: move to the next column.
            src_row_in = '0;
            rib_in     = '0;
            orc_in     = '0;
            src_col_in = col_next[ibpd_pkg::ROW_BITS-1:0];
            cib_in     = cib_next[ibpd_pkg::IN_BLOCK_BITS-1:0];
            if (cib_next >= cfg.width_factor) begin
               cib_in = '0;
               occ_in = occ_ff + 1'b1;
            end
            if (col_next >= cfg.source_width) begin
               src_col_in = '0;
               cib_in     = '0;
               occ_in     = '0;
            end
         end
      end
      if (cfg.restart) begin
         src_row_in = '0;
         src_col_in = '0;
         rib_in     = '0;
         cib_in     = '0;
         orc_in     = '0;
         occ_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_row_ff <= '0;
         src_col_ff <= '0;
         rib_ff     <= '0;
         cib_ff     <= '0;
         orc_ff     <= '0;
         occ_ff     <= '0;
      end else begin
         src_row_ff <= src_row_in;
         src_col_ff <= src_col_in;
         rib_ff     <= rib_in;
         cib_ff     <= cib_in;
         orc_ff     <= orc_in;
         occ_ff     <= occ_in;
      end
   end

endmodule

// ----- sv/ibpd_fifo.sv -----
// Short item queue between the front end and the pooling engine.
module ibpd_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ibpd_pkg::item_type  push_item,
   input  logic                pop,
   output ibpd_pkg::item_type  head_item,
   output logic                full,
   output logic                empty
);

   ibpd_pkg::item_type                 slot_ff [ibpd_pkg::QUEUE_DEPTH];
   logic [ibpd_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [ibpd_pkg::QUEUE_PTR_BITS:0]   count_ff;
   logic                                do_push, do_pop;

   assign full      = count_ff == (ibpd_pkg::QUEUE_PTR_BITS+1)'(ibpd_pkg::QUEUE_DEPTH);
   assign empty     = count_ff == '0;
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_item = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ----- sv/ibpd_back.sv -----
// Pooling engine: accumulator read-modify-write, serial divider, result register.
module ibpd_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ibpd_pkg::cfg_type                    cfg,
   input  logic                                 q_empty,
   input  ibpd_pkg::item_type                   q_head,
   output logic                                 q_pop,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [ibpd_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   output logic                                 rsp_tlast,
   output logic                                 rsp_tuser
);

   ibpd_pkg::back_state_type             state_ff, state_in;
   ibpd_pkg::item_type                   item_ff, item_in;
   logic [ibpd_pkg::ACC_BITS-1:0]        value_ff, value_in;
   logic [ibpd_pkg::DIV_BITS-1:0]        rem_ff, rem_in, divisor_ff, divisor_in;
   logic [ibpd_pkg::DIV_STEP_BITS-1:0]   step_ff, step_in;
   logic [ibpd_pkg::DIV_BITS:0]          rem_shift;
   logic [ibpd_pkg::ACC_BITS:0]          sum;
   logic [ibpd_pkg::ACC_BITS-1:0]        acc, pix_ext, ram_rdata;
   logic                                 ram_we, ram_re, load_out;
   logic                                 out_valid_ff;
   logic [ibpd_pkg::RSP_DATA_BITS-1:0]   out_data_ff;
   logic                                 out_last_ff, out_bad_ff;

   ibpd_ram #(
      .WIDTH(ibpd_pkg::ACC_BITS),
      .DEPTH(ibpd_pkg::MAX_SOURCE_HEIGHT)
   ) u_acc_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (item_ff.row[ibpd_pkg::ROW_BITS-1:0]),
      .wr_data (acc),
      .rd_en   (ram_re),
      .rd_addr (q_head.row[ibpd_pkg::ROW_BITS-1:0]),
      .rd_data (ram_rdata)
   );

   assign pix_ext = ibpd_pkg::ACC_BITS'(item_ff.pixel);
   assign sum     = {1'b0, ram_rdata} + {1'b0, pix_ext};

   always_comb begin
      if (item_ff.first) begin
         acc = pix_ext;
      end else if (cfg.pool_mode == ibpd_pkg::MODE_MAX) begin
         acc = (ram_rdata < pix_ext) ? pix_ext : ram_rdata;
      end else if (sum[ibpd_pkg::ACC_BITS]) begin
         acc = '1;
      end else begin
         acc = sum[ibpd_pkg::ACC_BITS-1:0];
      end
   end

   // value_ff doubles as dividend and quotient during the restoring division.
   assign rem_shift = {rem_ff, value_ff[ibpd_pkg::ACC_BITS-1]};

   always_comb begin
      state_in   = state_ff;
      item_in    = item_ff;
      value_in   = value_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      step_in    = step_ff;
      q_pop      = 1'b0;
      ram_re     = 1'b0;
      ram_we     = 1'b0;
      load_out   = 1'b0;
      case (state_ff)
         ibpd_pkg::BK_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               ram_re   = 1'b1;
               item_in  = q_head;
               value_in = '0;
               state_in = q_head.bad ? ibpd_pkg::BK_OUTPUT : ibpd_pkg::BK_UPDATE;
            end
         end
         ibpd_pkg::BK_UPDATE: begin
            ram_we   = 1'b1;
            value_in = acc;
            if (!item_ff.emit) begin
               state_in = ibpd_pkg::BK_IDLE;
            end else if (cfg.pool_mode == ibpd_pkg::MODE_AVG) begin
               rem_in     = '0;
               step_in    = '0;
               divisor_in = cfg.height_factor * cfg.width_factor;
               state_in   = ibpd_pkg::BK_DIVIDE;
            end else begin
               state_in = ibpd_pkg::BK_OUTPUT;
            end
         end
         ibpd_pkg::BK_DIVIDE: begin
            if (rem_shift >= {1'b0, divisor_ff}) begin
               rem_in   = ibpd_pkg::DIV_BITS'(rem_shift - {1'b0, divisor_ff});
               value_in = {value_ff[ibpd_pkg::ACC_BITS-2:0], 1'b1};
            end else begin
               rem_in   = rem_shift[ibpd_pkg::DIV_BITS-1:0];
               value_in = {value_ff[ibpd_pkg::ACC_BITS-2:0], 1'b0};
            end
            step_in = step_ff + 1'b1;
            if (step_ff == '1) begin
               state_in = ibpd_pkg::BK_OUTPUT;
            end
         end
         ibpd_pkg::BK_OUTPUT: begin
            if (!out_valid_ff || rsp_tready) begin
               load_out = 1'b1;
               state_in = ibpd_pkg::BK_IDLE;
            end
         end
         default: state_in = ibpd_pkg::BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ibpd_pkg::BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_out) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      item_ff    <= item_in;
      value_ff   <= value_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      step_ff    <= step_in;
      if (load_out) begin
         out_data_ff <= {item_ff.row, item_ff.column, value_ff};
         out_last_ff <= item_ff.last;
         out_bad_ff  <= item_ff.bad;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_bad_ff;

endmodule

// ----- sv/image_block_pool_downsample_unit.sv -----
// The engine takes one item at a time: idle, then update for a pixel that closes no block;
// a non-average result then goes to output, an average result first through the restoring
// divider (one quotient bit per cycle). A bad-config item goes from idle straight to output.
// Each accumulator update is a read then a write of the accumulator RAM, one item at a time.
// Reset: registers go to 1/1/1/1/sum and the scan to the image start; the RAM is not cleared.
// After a register write, input is held off while the size/factor check runs.
module image_block_pool_downsample_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [ibpd_pkg::REQ_DATA_BITS-1:0]   req_tdata,   // [23:0] pixel_value
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [ibpd_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,   // [31:0] pooled_value,
                                                             // [43:32] out_column,
                                                             // [55:44] out_row
   output logic                                 rsp_tlast,   // last_of_image
   output logic                                 rsp_tuser,   // [0] bad_config
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [ibpd_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [ibpd_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [ibpd_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                 csr_pready
);

   ibpd_pkg::cfg_type  cfg;
   ibpd_pkg::item_type push_item, head_item;
   logic               q_push, q_pop, q_full, q_empty;

   ibpd_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ibpd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_item     (push_item)
   );

   ibpd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .head_item (head_item),
      .full      (q_full),
      .empty     (q_empty)
   );

   ibpd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .q_empty    (q_empty),
      .q_head     (head_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // No pixel may enter while the divisibility check is still running.
   a_no_accept_during_check: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> !cfg.busy)
      else $error("pixel accepted during configuration check");

   // The queue must never be pushed when full.
   a_no_queue_overflow: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_full))
      else $error("item queue overflow");

   // A bad-configuration result carries zero data and no end-of-image mark.
   a_bad_result_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0 && !rsp_tlast))
      else $error("bad configuration result carries data");

   // The queue is only popped when it holds an item.
   a_no_queue_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("item queue underflow");

endmodule

// ----- tb/sv/image_block_pool_downsample_unit_tb.sv -----
// Self-checking testbench for the block pooling downsampler.
`timescale 1ns / 1ps

module image_block_pool_downsample_unit_tb;
   import ibpd_pkg::*;

   localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;
   localparam int RANDOM_PIXELS  = 750;
   localparam int RANDOM_RESULTS = 60;
   localparam int SETTLE_CYCLES  = 40;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      logic [ACC_BITS-1:0]       pooled;
      logic [OUT_INDEX_BITS-1:0] column;
      logic [OUT_INDEX_BITS-1:0] row;
      logic                      last;
      logic                      bad;
   } block_result_t;

   typedef enum bit {STEP_REGISTER, STEP_PIXEL} step_kind_e;

   typedef struct {
      step_kind_e    kind;
      logic [2:0]    index;
      logic [31:0]   value;
      bit            typed;
      bit            emits;
      block_result_t want;
   } plan_row_t;

   localparam block_result_t NO_RESULT  = '0;
   localparam block_result_t BAD_RESULT =
      '{pooled: '0, column: '0, row: '0, last: 1'b0, bad: 1'b1};

   logic                       clock;
   logic                       reset       = 1'b1;
   logic                       req_tvalid  = 1'b0;
   logic                       req_tready;
   logic [REQ_DATA_BITS-1:0]   req_tdata   = '0;   // [23:0] pixel_value
   logic                       rsp_tvalid;
   logic                       rsp_tready  = 1'b0;
   logic [RSP_DATA_BITS-1:0]   rsp_tdata;          // [31:0] pooled_value, [43:32] out_column,
                                                   // [55:44] out_row
   logic                       rsp_tlast;          // last_of_image
   logic                       rsp_tuser;          // [0] bad_config
   logic                       csr_psel    = 1'b0;
   logic                       csr_penable = 1'b0;
   logic                       csr_pwrite  = 1'b0;
   logic [CSR_ADDR_BITS-1:0]   csr_paddr   = '0;
   logic [CSR_DATA_BITS-1:0]   csr_pwdata  = '0;
   logic [CSR_DATA_BITS-1:0]   csr_prdata;
   logic                       csr_pready;

   image_block_pool_downsample_unit dut (.*);

   // Predictor state: register copies and the scan position of the image.
   logic [SIZE_REG_BITS-1:0]   cfg_height = 13'd1;
   logic [SIZE_REG_BITS-1:0]   cfg_width  = 13'd1;
   logic [FACTOR_REG_BITS-1:0] cfg_hf     = 5'd1;
   logic [FACTOR_REG_BITS-1:0] cfg_wf     = 5'd1;
   logic [MODE_BITS-1:0]       cfg_mode   = MODE_SUM;
   logic [ACC_BITS-1:0]        acc_store [MAX_SOURCE_HEIGHT];
   logic [SIZE_REG_BITS-1:0]   scan_row = '0, scan_col = '0, blk_row = '0, blk_col = '0;
   logic [FACTOR_REG_BITS-1:0] row_in_blk = '0, col_in_blk = '0;

   block_result_t expected_blocks [$];
   plan_row_t     plan [$];

   bit sender_steady = 1'b0;
   bit csr_open      = 1'b0;
   int stall_left = 0, calm_left = 0, quiet_cycles = 0;
   int failures = 0, pixels_sent = 0, blocks_predicted = 0;
   int blocks_checked = 0, bad_checked = 0, registers_written = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic void restart_scan();
      scan_row   = '0;
      scan_col   = '0;
      row_in_blk = '0;
      col_in_blk = '0;
      blk_row    = '0;
      blk_col    = '0;
   endfunction

   // Bad setup: returns 1. Else steps the scan one pixel, returning 1 if it closes a block.
   function automatic bit pool_pixel(input logic [PIXEL_BITS-1:0] pixel,
                                     output block_result_t res);
      logic [ACC_BITS:0]         total;
      logic [ACC_BITS-1:0]       acc;
      logic [OUT_INDEX_BITS-1:0] slot;
      bit                        usable;
      bit                        emits;
      res = '0;
      usable = cfg_height != 0 && cfg_height <= 13'(MAX_SOURCE_HEIGHT)
            && cfg_width != 0 && cfg_width <= 13'(MAX_SOURCE_HEIGHT)
            && cfg_hf != 0 && cfg_hf <= 5'(MAX_FACTOR)
            && cfg_wf != 0 && cfg_wf <= 5'(MAX_FACTOR);
      if (usable)
         usable = (cfg_height % 13'(cfg_hf) == 0) && (cfg_width % 13'(cfg_wf) == 0);
      if (!usable) begin
         res.bad = 1'b1;
         return 1'b1;
      end
      slot = blk_row[OUT_INDEX_BITS-1:0];
      if (row_in_blk == 0 && col_in_blk == 0) begin
         acc = ACC_BITS'(pixel);
      end else if (cfg_mode == MODE_MAX) begin
         acc = (acc_store[slot] < ACC_BITS'(pixel)) ? ACC_BITS'(pixel) : acc_store[slot];
      end else begin
         // Sum, average and the unused mode code all add, saturating at the top.
         total = {1'b0, acc_store[slot]} + {9'd0, pixel};
         acc = total[ACC_BITS] ? '1 : total[ACC_BITS-1:0];
      end
      acc_store[slot] = acc;
      emits = (row_in_blk == cfg_hf - 5'd1) && (col_in_blk == cfg_wf - 5'd1);
      if (emits) begin
         res.pooled = (cfg_mode == MODE_AVG) ? acc / (32'(cfg_hf) * 32'(cfg_wf)) : acc;
         res.column = blk_col[OUT_INDEX_BITS-1:0];
         res.row    = blk_row[OUT_INDEX_BITS-1:0];
         res.last   = (scan_row == cfg_height - 13'd1) && (scan_col == cfg_width - 13'd1);
      end
      row_in_blk++;
      scan_row++;
      if (row_in_blk >= cfg_hf) begin
         row_in_blk = '0;
         blk_row++;
      end
      if (scan_row >= cfg_height) begin
         scan_row   = '0;
         row_in_blk = '0;
         blk_row    = '0;
         col_in_blk++;
         scan_col++;
         if (col_in_blk >= cfg_wf) begin
            col_in_blk = '0;
            blk_col++;
         end
         if (scan_col >= cfg_width) restart_scan();
      end
      return emits;
   endfunction

   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [PIXEL_BITS-1:0] pick_pixel();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) return '0;
      if (r < 16) return '1;
      return PIXEL_BITS'($urandom());
   endfunction

   function automatic block_result_t whole_image(input logic [ACC_BITS-1:0] value);
      return '{pooled: value, column: '0, row: '0, last: 1'b1, bad: 1'b0};
   endfunction

   function automatic plan_row_t reg_row(input logic [2:0] index, input logic [31:0] value);
      return '{kind: STEP_REGISTER, index: index, value: value, typed: 1'b0, emits: 1'b0,
               want: NO_RESULT};
   endfunction

   function automatic plan_row_t pixel_row(input logic [PIXEL_BITS-1:0] pixel, input bit typed,
                                           input bit emits, input block_result_t want);
      return '{kind: STEP_PIXEL, index: '0, value: 32'(pixel), typed: typed, emits: emits,
               want: want};
   endfunction

   task automatic wait_idle();
      while (expected_blocks.size() != 0) @(posedge clock);
      // A pixel that closes no block may still be in flight; let it retire.
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Back-to-back writes keep psel high and start the next setup phase directly.
   task automatic write_register(input logic [2:0] index, input logic [31:0] value);
      if (!csr_open) begin
         req_tvalid <= 1'b0;
         wait_idle();
         csr_open = 1'b1;
      end
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (index)
         REG_SOURCE_HEIGHT: cfg_height = value[SIZE_REG_BITS-1:0];
         REG_SOURCE_WIDTH:  cfg_width  = value[SIZE_REG_BITS-1:0];
         REG_HEIGHT_FACTOR: cfg_hf     = value[FACTOR_REG_BITS-1:0];
         REG_WIDTH_FACTOR:  cfg_wf     = value[FACTOR_REG_BITS-1:0];
         REG_POOL_MODE:     cfg_mode   = value[MODE_BITS-1:0];
         default: ;
      endcase
      restart_scan();
      registers_written++;
   endtask

   task automatic load_setting(input int height, input int width, input int hf, input int wf,
                               input int mode);
      write_register(REG_SOURCE_HEIGHT, 32'(height));
      write_register(REG_SOURCE_WIDTH, 32'(width));
      write_register(REG_HEIGHT_FACTOR, 32'(hf));
      write_register(REG_WIDTH_FACTOR, 32'(wf));
      write_register(REG_POOL_MODE, 32'(mode));
   endtask

   // A typed row supplies its own expectation; the predictor still tracks the scan.
   task automatic send_pixel(input logic [PIXEL_BITS-1:0] pixel, input bit typed,
                             input bit typed_emits, input block_result_t typed_want);
      int            gap;
      bit            emits;
      block_result_t res;
      if (csr_open) begin
         csr_psel    <= 1'b0;
         csr_penable <= 1'b0;
         csr_open = 1'b0;
      end
      gap = (sender_steady || $urandom_range(0, 99) >= 40) ? 0 : idle_length();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pixel;
      do @(posedge clock); while (!req_tready);
      pixels_sent++;
      emits = pool_pixel(pixel, res);
      if (typed) begin
         emits = typed_emits;
         res   = typed_want;
      end
      if (emits) begin
         expected_blocks.push_back(res);
         blocks_predicted++;
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin : result_check
      block_result_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_blocks.size() == 0) begin
            $error("result item with nothing expected: tdata=0x%0h", rsp_tdata);
            failures++;
         end else begin
            want = expected_blocks.pop_front();
            check_field("pooled_value", want.pooled, rsp_tdata[31:0]);
            check_field("out_column", 32'(want.column), 32'(rsp_tdata[43:32]));
            check_field("out_row", 32'(want.row), 32'(rsp_tdata[55:44]));
            check_field("last_of_image", 32'(want.last), 32'(rsp_tlast));
            check_field("bad_config", 32'(want.bad), 32'(rsp_tuser));
            blocks_checked++;
            if (want.bad) bad_checked++;
         end
      end
      // Result-side back-pressure, with occasional long stretches of none.
      if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
         if (calm_left != 0) calm_left--;
         else if ($urandom_range(0, 99) < 20) stall_left = idle_length();
         else if ($urandom_range(0, 199) == 0) calm_left = $urandom_range(100, 400);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int h, w, hf, wf, mode, area, count, base_blocks, random_pixels;
      int ext_h [3] = '{MAX_SOURCE_HEIGHT, 1, MAX_FACTOR};
      int ext_w [3] = '{1, MAX_SOURCE_HEIGHT, MAX_FACTOR};
      int ext_f [3] = '{1, 1, MAX_FACTOR};
      int ext_m [3] = '{MODE_SUM, MODE_MAX, MODE_AVG};

      // After reset every pixel is a whole 1x1 image on its own.
      plan.push_back(pixel_row(24'h000000, 1, 1, whole_image(32'h000000)));
      plan.push_back(pixel_row(24'hFFFFFF, 1, 1, whole_image(32'hFFFFFF)));
      plan.push_back(reg_row(REG_POOL_MODE, 32'(MODE_AVG)));
      plan.push_back(pixel_row(24'hABCDEF, 1, 1, whole_image(32'hABCDEF)));
      plan.push_back(reg_row(REG_POOL_MODE, 32'(MODE_MAX)));
      plan.push_back(pixel_row(24'h123456, 1, 1, whole_image(32'h123456)));
      plan.push_back(reg_row(REG_POOL_MODE, 32'(MODE_UNUSED)));
      plan.push_back(pixel_row(24'h800001, 1, 1, whole_image(32'h800001)));
      // Unusable settings: zero size, oversize, indivisible, zero and oversize factors.
      plan.push_back(reg_row(REG_SOURCE_HEIGHT, 32'd0));
      plan.push_back(pixel_row(24'h000005, 1, 1, BAD_RESULT));
      plan.push_back(reg_row(REG_SOURCE_HEIGHT, 32'd8191));
      plan.push_back(pixel_row(24'h7FFFFF, 1, 1, BAD_RESULT));
      plan.push_back(reg_row(REG_SOURCE_HEIGHT, 32'd3));
      plan.push_back(reg_row(REG_HEIGHT_FACTOR, 32'd2));
      plan.push_back(pixel_row(24'hFFFFFF, 1, 1, BAD_RESULT));
      plan.push_back(reg_row(REG_HEIGHT_FACTOR, 32'd0));
      plan.push_back(pixel_row(24'h000001, 1, 1, BAD_RESULT));
      plan.push_back(reg_row(REG_HEIGHT_FACTOR, 32'd31));
      plan.push_back(pixel_row(24'h555555, 1, 1, BAD_RESULT));
      plan.push_back(reg_row(REG_HEIGHT_FACTOR, 32'd2));
      plan.push_back(reg_row(REG_SOURCE_HEIGHT, 32'd2));
      plan.push_back(reg_row(REG_SOURCE_WIDTH, 32'd0));
      plan.push_back(pixel_row(24'hAAAAAA, 1, 1, BAD_RESULT));
      // One 2x2 block per image in sum, average and max mode.
      plan.push_back(reg_row(REG_SOURCE_WIDTH, 32'd2));
      plan.push_back(reg_row(REG_WIDTH_FACTOR, 32'd2));
      plan.push_back(reg_row(REG_POOL_MODE, 32'(MODE_SUM)));
      plan.push_back(pixel_row(24'hFFFFFF, 1, 0, NO_RESULT));
      plan.push_back(pixel_row(24'hFFFFFF, 1, 0, NO_RESULT));
      plan.push_back(pixel_row(24'hFFFFFF, 1, 0, NO_RESULT));
      plan.push_back(pixel_row(24'hFFFFFF, 1, 1, whole_image(32'h03FFFFFC)));
      plan.push_back(reg_row(REG_POOL_MODE, 32'(MODE_AVG)));
      plan.push_back(pixel_row(24'h000001, 0, 0, NO_RESULT));
      plan.push_back(pixel_row(24'h000002, 0, 0, NO_RESULT));
      plan.push_back(pixel_row(24'h000003, 0, 0, NO_RESULT));
      plan.push_back(pixel_row(24'h000007, 0, 0, NO_RESULT));
      plan.push_back(reg_row(REG_POOL_MODE, 32'(MODE_MAX)));
      plan.push_back(pixel_row(24'h7FFFFF, 0, 0, NO_RESULT));
      plan.push_back(pixel_row(24'h800000, 0, 0, NO_RESULT));
      plan.push_back(pixel_row(24'h000000, 0, 0, NO_RESULT));
      plan.push_back(pixel_row(24'h000010, 0, 0, NO_RESULT));

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == STEP_REGISTER)
            write_register(plan[i].index, plan[i].value);
         else
            send_pixel(plan[i].value[PIXEL_BITS-1:0], plan[i].typed, plan[i].emits,
                       plan[i].want);
      end

      // Largest images and factors: full 4096-row and 4096-column scans, one 16x16 block.
      for (int e = 0; e < 3; e++) begin
         sender_steady = ($urandom_range(0, 3) == 0);
         load_setting(ext_h[e], ext_w[e], ext_f[e], ext_f[e], ext_m[e]);
         repeat (ext_h[e] * ext_w[e]) send_pixel(pick_pixel(), 0, 0, NO_RESULT);
      end

      base_blocks   = blocks_predicted;
      random_pixels = 0;
      while (random_pixels < RANDOM_PIXELS || blocks_predicted - base_blocks < RANDOM_RESULTS)
      begin
         hf   = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 4)
                                             : $urandom_range(5, MAX_FACTOR);
         wf   = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 4)
                                             : $urandom_range(5, MAX_FACTOR);
         h    = hf * $urandom_range(1, (hf > 4) ? 2 : 6);
         w    = wf * $urandom_range(1, (wf > 4) ? 2 : 6);
         mode = $urandom_range(0, 3);
         if ($urandom_range(0, 99) < 12) begin
            case ($urandom_range(0, 5))
               0: h = 0;
               1: w = 0;
               2: if ($urandom_range(0, 1) == 1) h = $urandom_range(MAX_SOURCE_HEIGHT + 1, 8191);
                  else w = $urandom_range(MAX_SOURCE_HEIGHT + 1, 8191);
               3: if ($urandom_range(0, 1) == 1) hf = 0;
                  else wf = 0;
               4: if ($urandom_range(0, 1) == 1) hf = $urandom_range(MAX_FACTOR + 1, 31);
                  else wf = $urandom_range(MAX_FACTOR + 1, 31);
               default: begin
                  // Size one to hf-1 rows past a multiple of the factor.
                  hf = $urandom_range(2, MAX_FACTOR);
                  h  = hf * $urandom_range(1, 4) + $urandom_range(1, hf - 1);
               end
            endcase
            count = $urandom_range(2, 8);
         end else begin
            area  = h * w;
            count = area * $urandom_range(1, 2);
            // Sometimes add part of another image so the next write lands mid-image.
            if (area > 1 && $urandom_range(0, 3) == 0) count += $urandom_range(1, area - 1);
         end
         sender_steady = ($urandom_range(0, 3) == 0);
         load_setting(h, w, hf, wf, mode);
         repeat (count) send_pixel(pick_pixel(), 0, 0, NO_RESULT);
         random_pixels += count;
      end

      req_tvalid <= 1'b0;
      wait_idle();
      $display("Sent %0d pixels under %0d register writes; checked %0d result items (%0d bad).",
               pixels_sent, registers_written, blocks_checked, bad_checked);
      $display("Modes sum/average/max/unused, factors 1 to 16, images up to 4096 deep or wide.");
      if (failures == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
